// File: rtl/ccoq_pkg.sv
// ----------------------------------------------------------------------------
// ccoq_pkg: shared types, constants and functions
// Request codes, table entry layout, quarter-wave sine table and saturation.
// ----------------------------------------------------------------------------
package ccoq_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 16 + IDX_W;
    localparam int QDEPTH  = 2;
    localparam logic [15:0] NO_ENTITY_ID = 16'd0;

    localparam logic [2:0] REQ_LOAD    = 3'd0;
    localparam logic [2:0] REQ_SOLID   = 3'd1;
    localparam logic [2:0] REQ_LISTC   = 3'd2;
    localparam logic [2:0] REQ_LISTT   = 3'd3;
    localparam logic [2:0] REQ_RESOLVE = 3'd4;

    localparam logic [1:0] MK_FULL  = 2'd0;
    localparam logic [1:0] MK_XONLY = 2'd1;
    localparam logic [1:0] MK_ZONLY = 2'd2;
    localparam logic [1:0] MK_STOP  = 2'd3;

    localparam logic [3:0] LOAD_LAST = 4'd8;

    typedef enum logic [2:0] {
        OP_LOAD, OP_SOLID, OP_LISTC, OP_LISTT, OP_RESOLVE
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE, ST_LOAD, ST_SCAN, ST_EMIT
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [5:0]         slot;
        logic [15:0]        eid;
        logic [1:0]         flags;
        logic signed [31:0] ax;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] bz;
        logic signed [31:0] sx;
        logic signed [31:0] sz;
        logic signed [31:0] radius;
        logic [15:0]        yaw;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [15:0]        hit_id;
        logic signed [31:0] out_x;
        logic signed [31:0] out_z;
        logic [1:0]         move_kind;
        logic               last;
    } t_res;

    typedef struct packed {
        logic [15:0]        id;
        logic [1:0]         flags;
        logic signed [31:0] cx;
        logic signed [31:0] cz;
        logic signed [31:0] rad;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam logic [16:0] QW [17] = '{
        17'd0, 17'd6424, 17'd12785, 17'd19024, 17'd25080, 17'd30893, 17'd36410,
        17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798, 17'd60547,
        17'd62714, 17'd64277, 17'd65220, 17'd65536
    };

    localparam logic signed [51:0] S_MAX = 52'sd2147483647;
    localparam logic signed [51:0] S_MIN = -52'sd2147483648;

    function automatic logic [16:0] quarter_sin(input logic [14:0] p);
        logic [4:0]  i;
        logic [9:0]  f;
        logic [12:0] d;
        logic [23:0] t;
        i = p[14:10];
        f = p[9:0];
        if (i[4]) begin
            return QW[16];
        end
        d = 13'(QW[i + 5'd1] - QW[i]);
        t = 24'(d * f) + 24'd512;
        return QW[i] + 17'(t[23:10]);
    endfunction

    function automatic logic signed [17:0] full_sin(input logic [15:0] a);
        logic [14:0] arg;
        logic [16:0] v;
        arg = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        v = quarter_sin(arg);
        return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        if (v > S_MAX) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < S_MIN) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// File: rtl/ccoq_ram.sv
// ----------------------------------------------------------------------------
// ccoq_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ccoq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/ccoq_front.sv
// ----------------------------------------------------------------------------
// ccoq_front: request intake and decode
// Accepts requests, drops unused codes, queues decoded requests for the back end.
// ----------------------------------------------------------------------------
module ccoq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [2:0]         i_req_type,
    input  logic [5:0]         i_slot,
    input  logic [15:0]        i_entity_id,
    input  logic [1:0]         i_flags,
    input  logic signed [31:0] i_coord_a_x,
    input  logic signed [31:0] i_coord_a_z,
    input  logic signed [31:0] i_coord_b_x,
    input  logic signed [31:0] i_coord_b_z,
    input  logic signed [31:0] i_scale_x,
    input  logic signed [31:0] i_scale_z,
    input  logic signed [31:0] i_radius,
    input  logic [15:0]        i_yaw_angle,
    output logic               o_full,
    output logic               o_req_valid,
    output ccoq_pkg::t_req     o_req,
    input  logic               i_req_ready
);
    localparam int QAW = (ccoq_pkg::QDEPTH > 1) ? $clog2(ccoq_pkg::QDEPTH) : 1;

    ccoq_pkg::t_req r_q [ccoq_pkg::QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    ccoq_pkg::t_req w_dec;
    logic           w_code_ok, w_wr, w_rd;

    always_comb begin
        w_code_ok = 1'b1;
        w_dec.op  = ccoq_pkg::OP_LOAD;
        unique case (i_req_type)
            ccoq_pkg::REQ_LOAD:    w_dec.op = ccoq_pkg::OP_LOAD;
            ccoq_pkg::REQ_SOLID:   w_dec.op = ccoq_pkg::OP_SOLID;
            ccoq_pkg::REQ_LISTC:   w_dec.op = ccoq_pkg::OP_LISTC;
            ccoq_pkg::REQ_LISTT:   w_dec.op = ccoq_pkg::OP_LISTT;
            ccoq_pkg::REQ_RESOLVE: w_dec.op = ccoq_pkg::OP_RESOLVE;
            default:               w_code_ok = 1'b0;
        endcase
        w_dec.slot   = i_slot;
        w_dec.eid    = i_entity_id;
        w_dec.flags  = i_flags;
        w_dec.ax     = i_coord_a_x;
        w_dec.az     = i_coord_a_z;
        w_dec.bx     = i_coord_b_x;
        w_dec.bz     = i_coord_b_z;
        w_dec.sx     = i_scale_x;
        w_dec.sz     = i_scale_z;
        w_dec.radius = i_radius;
        w_dec.yaw    = i_yaw_angle;
    end

    assign o_full      = (r_cnt == (QAW+1)'(ccoq_pkg::QDEPTH));
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];
    assign w_wr        = i_push && !o_full && w_code_ok;
    assign w_rd        = o_req_valid && i_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == QAW'(ccoq_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == QAW'(ccoq_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(w_wr) - (QAW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_dec;
        end
    end
endmodule

// File: rtl/ccoq_back.sv
// ----------------------------------------------------------------------------
// ccoq_back: collider table and request execution
// Load transform on a shared multiplier, slot walks for queries, result register.
// ----------------------------------------------------------------------------
module ccoq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  ccoq_pkg::t_req i_req,
    output logic           o_req_ready,
    input  logic           i_pop,
    output logic           o_empty,
    output ccoq_pkg::t_res o_res
);
    localparam int IW = ccoq_pkg::IDX_W;
    localparam int KW = ccoq_pkg::KEY_W;
    localparam logic [IW-1:0] LAST_K = IW'(ccoq_pkg::ENTRIES - 1);

    ccoq_pkg::t_state r_state, n_state;
    ccoq_pkg::t_req   r_req, n_req;
    logic [3:0]       r_ph, n_ph;
    logic [IW-1:0]    r_k, n_k;
    logic [1:0]       r_pass, n_pass;
    logic [ccoq_pkg::ENTRIES-1:0] r_valid, n_valid;
    logic signed [17:0] r_sin, r_cos, n_sin, n_cos;
    logic signed [31:0] r_lx, r_lz, r_rad, n_lx, n_lz, n_rad;
    logic signed [34:0] r_accx, r_accz, n_accx, n_accz;
    logic [32:0]        r_dx, r_dz, r_csum, n_dx, n_dz, n_csum;
    logic [KW-1:0]      r_curkey, r_best, r_lastkey, r_pendk;
    logic [KW-1:0]      n_curkey, n_best, n_lastkey, n_pendk;
    logic               r_found, r_havelast, r_pend, n_found, n_havelast, n_pend;
    logic signed [67:0] r_prod;
    logic [64:0]        r_sx, r_sz, n_sx, n_sz;
    ccoq_pkg::t_res     r_res, n_res, r_out, n_out, w_res;
    logic               r_cont, n_cont, r_out_valid, n_out_valid, w_cont;

    logic [ccoq_pkg::ENTRY_W-1:0] w_rdata;
    ccoq_pkg::t_entry   w_ent, w_wentry;
    logic               w_we;
    logic signed [31:0] w_px, w_pz;
    logic signed [32:0] w_dxs, w_dzs;
    logic [31:0]        w_ra, w_rb, w_mx, w_mz, w_m;
    logic [KW-1:0]      w_key, w_best_now;
    logic               w_elig, w_is_list, w_p1, w_p5, w_qhit, w_hitnow, w_adv, w_eop;
    logic               w_found_now, w_to_emit, w_restart, w_out_free;
    logic signed [33:0] w_ma, w_mb;
    logic signed [51:0] w_q;

    ccoq_ram #(.WIDTH(ccoq_pkg::ENTRY_W), .DEPTH(ccoq_pkg::ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_req.slot[IW-1:0]),
        .i_wdata (w_wentry),
        .i_raddr (r_k),
        .o_rdata (w_rdata)
    );

    assign w_ent      = ccoq_pkg::t_entry'(w_rdata);
    assign w_out_free = !r_out_valid || i_pop;
    assign w_q        = r_prod[67:16];
    assign w_is_list  = (r_req.op == ccoq_pkg::OP_LISTC) || (r_req.op == ccoq_pkg::OP_LISTT);

    // query point by operation and resolve pass
    always_comb begin
        w_px = r_req.ax;
        w_pz = r_req.az;
        if (r_req.op == ccoq_pkg::OP_RESOLVE) begin
            case (r_pass)
                2'd0:    begin w_px = r_req.bx; w_pz = r_req.bz; end
                2'd1:    begin w_px = r_req.bx; w_pz = r_req.az; end
                default: begin w_px = r_req.ax; w_pz = r_req.bz; end
            endcase
        end
    end

    always_comb begin
        w_dxs = $signed({w_px[31], w_px}) - $signed({w_ent.cx[31], w_ent.cx});
        w_dzs = $signed({w_pz[31], w_pz}) - $signed({w_ent.cz[31], w_ent.cz});
        w_ra  = r_req.radius[31] ? 32'd0 : r_req.radius;
        w_rb  = w_ent.rad[31] ? 32'd0 : w_ent.rad;
        w_key = {w_ent.id, r_k};
        w_elig = r_valid[r_k] && w_ent.flags[0]
              && !((r_req.eid != ccoq_pkg::NO_ENTITY_ID) && (w_ent.id == r_req.eid));
        case (r_req.op)
            ccoq_pkg::OP_LISTC: w_elig = w_elig && (!w_ent.flags[1] || r_req.flags[0]);
            ccoq_pkg::OP_LISTT: w_elig = w_elig && w_ent.flags[1];
            default:            w_elig = w_elig && !w_ent.flags[1];
        endcase
        if (w_is_list) begin
            w_elig = w_elig && (!r_havelast || (w_key > r_lastkey))
                            && (!r_found || (w_key < r_best));
        end
        w_mx = r_req.sx[31] ? 32'(-r_req.sx) : r_req.sx;
        w_mz = r_req.sz[31] ? 32'(-r_req.sz) : r_req.sz;
        w_m  = (w_mx > w_mz) ? w_mx : w_mz;
    end

    // shared multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == ccoq_pkg::ST_LOAD) begin
            case (r_ph)
                4'd0: begin w_ma = 34'(r_req.bx); w_mb = 34'(r_req.sx); end
                4'd1: begin w_ma = 34'(r_req.bz); w_mb = 34'(r_req.sz); end
                4'd2: begin w_ma = 34'(r_req.radius); w_mb = $signed({2'b00, w_m}); end
                4'd3: begin w_ma = 34'(r_lx); w_mb = 34'(r_cos); end
                4'd4: begin w_ma = 34'(r_lz); w_mb = 34'(r_sin); end
                4'd5: begin w_ma = 34'(r_lx); w_mb = 34'(r_sin); end
                4'd6: begin w_ma = 34'(r_lz); w_mb = 34'(r_cos); end
                default: ;
            endcase
        end else if (r_state == ccoq_pkg::ST_SCAN) begin
            case (r_ph)
                4'd2: begin w_ma = $signed({1'b0, r_dx}); w_mb = $signed({1'b0, r_dx}); end
                4'd3: begin w_ma = $signed({1'b0, r_dz}); w_mb = $signed({1'b0, r_dz}); end
                4'd4: begin
                    w_ma = $signed({1'b0, r_csum});
                    w_mb = $signed({1'b0, r_csum});
                end
                default: ;
            endcase
        end
    end

    // scan decisions
    always_comb begin
        w_p1        = (r_state == ccoq_pkg::ST_SCAN) && (r_ph == 4'd1);
        w_p5        = (r_state == ccoq_pkg::ST_SCAN) && (r_ph == 4'd5);
        w_qhit      = ({1'b0, r_sx} + {1'b0, r_sz}) < {1'b0, r_prod[64:0]};
        w_hitnow    = w_p5 && w_qhit;
        w_adv       = (w_p1 && !w_elig) || (w_p5 && (!w_qhit || w_is_list));
        w_eop       = w_adv && (r_k == LAST_K);
        w_found_now = r_found || (w_hitnow && w_is_list);
        w_best_now  = (w_hitnow && w_is_list) ? r_curkey : r_best;
        w_restart   = (w_hitnow && (r_req.op == ccoq_pkg::OP_RESOLVE) && (r_pass != 2'd2))
                   || (w_eop && w_is_list && w_found_now && !r_pend);
        w_to_emit   = (w_hitnow && (r_req.op == ccoq_pkg::OP_SOLID))
                   || (w_hitnow && (r_req.op == ccoq_pkg::OP_RESOLVE) && (r_pass == 2'd2))
                   || (w_eop && (!w_is_list || !w_found_now || r_pend));

        w_res  = '0;
        w_res.last = 1'b1;
        w_cont = 1'b0;
        case (r_req.op)
            ccoq_pkg::OP_SOLID: w_res.hit = w_hitnow;
            ccoq_pkg::OP_RESOLVE: begin
                if (w_hitnow) begin
                    w_res.hit       = 1'b1;
                    w_res.out_x     = r_req.ax;
                    w_res.out_z     = r_req.az;
                    w_res.move_kind = ccoq_pkg::MK_STOP;
                end else begin
                    w_res.hit   = (r_pass != 2'd0);
                    w_res.out_x = w_px;
                    w_res.out_z = w_pz;
                    case (r_pass)
                        2'd0:    w_res.move_kind = ccoq_pkg::MK_FULL;
                        2'd1:    w_res.move_kind = ccoq_pkg::MK_XONLY;
                        default: w_res.move_kind = ccoq_pkg::MK_ZONLY;
                    endcase
                end
            end
            default: begin
                w_res.hit    = r_pend;
                w_res.hit_id = r_pend ? r_pendk[KW-1:IW] : 16'd0;
                w_res.last   = !w_found_now;
                w_cont       = w_found_now;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ccoq_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req.op == ccoq_pkg::OP_LOAD) ? ccoq_pkg::ST_LOAD
                                                              : ccoq_pkg::ST_SCAN;
                end
            end
            ccoq_pkg::ST_LOAD: begin
                if (r_ph == ccoq_pkg::LOAD_LAST) begin
                    n_state = ccoq_pkg::ST_IDLE;
                end
            end
            ccoq_pkg::ST_SCAN: begin
                if (w_to_emit) begin
                    n_state = ccoq_pkg::ST_EMIT;
                end
            end
            ccoq_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = r_cont ? ccoq_pkg::ST_SCAN : ccoq_pkg::ST_IDLE;
                end
            end
            default: n_state = ccoq_pkg::ST_IDLE;
        endcase
    end

    assign w_we = (r_state == ccoq_pkg::ST_LOAD) && (r_ph == ccoq_pkg::LOAD_LAST)
               && ({1'b0, r_req.slot} < 7'(ccoq_pkg::ENTRIES));

    always_comb begin
        w_wentry.id    = r_req.eid;
        w_wentry.flags = r_req.flags;
        w_wentry.cx    = ccoq_pkg::sat32(52'(r_accx));
        w_wentry.cz    = ccoq_pkg::sat32(52'(r_accz));
        w_wentry.rad   = r_rad;
    end

    always_comb begin
        n_req = r_req; n_ph = r_ph; n_k = r_k; n_pass = r_pass; n_valid = r_valid;
        n_sin = r_sin; n_cos = r_cos; n_lx = r_lx; n_lz = r_lz; n_rad = r_rad;
        n_accx = r_accx; n_accz = r_accz; n_dx = r_dx; n_dz = r_dz; n_csum = r_csum;
        n_curkey = r_curkey; n_best = r_best; n_lastkey = r_lastkey; n_pendk = r_pendk;
        n_found = r_found; n_havelast = r_havelast; n_pend = r_pend;
        n_sx = r_sx; n_sz = r_sz; n_res = r_res; n_cont = r_cont;
        n_out = r_out; n_out_valid = r_out_valid;
        if (i_pop) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ccoq_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_req = i_req; n_ph = '0; n_k = '0; n_pass = '0;
                    n_found = 1'b0; n_havelast = 1'b0; n_pend = 1'b0;
                end
            end
            ccoq_pkg::ST_LOAD: begin
                n_ph = r_ph + 4'd1;
                case (r_ph)
                    4'd0: begin
                        n_sin = ccoq_pkg::full_sin(r_req.yaw);
                        n_cos = ccoq_pkg::full_sin(r_req.yaw + 16'd16384);
                    end
                    4'd1: n_lx = ccoq_pkg::sat32(w_q);
                    4'd2: n_lz = ccoq_pkg::sat32(w_q);
                    4'd3: n_rad = ccoq_pkg::sat32(w_q);
                    4'd4: n_accx = 35'(r_req.ax) + w_q[34:0];
                    4'd5: n_accx = r_accx + w_q[34:0];
                    4'd6: n_accz = 35'(r_req.az) - w_q[34:0];
                    4'd7: n_accz = r_accz + w_q[34:0];
                    default: begin
                        if (w_we) begin
                            n_valid[r_req.slot[IW-1:0]] = 1'b1;
                        end
                    end
                endcase
            end
            ccoq_pkg::ST_SCAN: begin
                case (r_ph)
                    4'd1: begin
                        n_dx     = w_dxs[32] ? 33'(-w_dxs) : 33'(w_dxs);
                        n_dz     = w_dzs[32] ? 33'(-w_dzs) : 33'(w_dzs);
                        n_csum   = {1'b0, w_ra} + {1'b0, w_rb};
                        n_curkey = w_key;
                        n_ph     = 4'd2;
                    end
                    4'd3: begin n_sx = r_prod[64:0]; n_ph = 4'd4; end
                    4'd4: begin n_sz = r_prod[64:0]; n_ph = 4'd5; end
                    default: n_ph = r_ph + 4'd1;
                endcase
                if (w_hitnow && w_is_list) begin
                    n_found = 1'b1;
                    n_best  = r_curkey;
                end
                if (w_adv && !w_eop) begin
                    n_k  = r_k + 1'b1;
                    n_ph = '0;
                end
                if (w_restart || (w_eop && w_is_list && w_found_now)) begin
                    n_k  = '0;
                    n_ph = '0;
                    if (w_is_list) begin
                        n_pend = 1'b1; n_pendk = w_best_now;
                        n_havelast = 1'b1; n_lastkey = w_best_now;
                        n_found = 1'b0;
                    end else begin
                        n_pass = r_pass + 2'd1;
                    end
                end
                if (w_to_emit) begin
                    n_res  = w_res;
                    n_cont = w_cont;
                end
            end
            ccoq_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ccoq_pkg::ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_ph        <= '0;
            r_k         <= '0;
            r_pass      <= '0;
            r_found     <= 1'b0;
            r_havelast  <= 1'b0;
            r_pend      <= 1'b0;
            r_cont      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_ph        <= n_ph;
            r_k         <= n_k;
            r_pass      <= n_pass;
            r_found     <= n_found;
            r_havelast  <= n_havelast;
            r_pend      <= n_pend;
            r_cont      <= n_cont;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_sin <= n_sin; r_cos <= n_cos;
        r_lx <= n_lx; r_lz <= n_lz; r_rad <= n_rad; r_accx <= n_accx; r_accz <= n_accz;
        r_dx <= n_dx; r_dz <= n_dz; r_csum <= n_csum; r_curkey <= n_curkey;
        r_best <= n_best; r_lastkey <= n_lastkey; r_pendk <= n_pendk;
        r_sx <= n_sx; r_sz <= n_sz; r_res <= n_res; r_out <= n_out;
        r_prod <= w_ma * w_mb;
    end

    assign o_req_ready = (r_state == ccoq_pkg::ST_IDLE);
    assign o_empty     = !r_out_valid;
    assign o_res       = r_out;
endmodule

// File: rtl/circle_collider_overlap_query.sv
// ----------------------------------------------------------------------------
// circle_collider_overlap_query: circle collider table with overlap queries
// Loads colliders in the XZ plane, answers overlap tests, id lists and slides.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// request   in         i_push / o_full    req_type .. yaw_angle
// result    out        o_empty / i_pop    hit, hit_id, out_x, out_z, move_kind, last
//
// Load runs on the shared multiplier. Query: a walk over all 64 slots, skipping
// ineligible slots early; resolve up to 3 passes, a list one pass per listed id
// plus one. Requests are handled one at a time by the back end.
// Reset clears the slot valid bits at once; no clearing pass.
// A two-deep request queue and the result register let each side stall alone.
// ----------------------------------------------------------------------------
module circle_collider_overlap_query (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [2:0]         i_req_type,
    input  logic [5:0]         i_slot,
    input  logic [15:0]        i_entity_id,
    input  logic [1:0]         i_flags,
    input  logic signed [31:0] i_coord_a_x,
    input  logic signed [31:0] i_coord_a_z,
    input  logic signed [31:0] i_coord_b_x,
    input  logic signed [31:0] i_coord_b_z,
    input  logic signed [31:0] i_scale_x,
    input  logic signed [31:0] i_scale_z,
    input  logic signed [31:0] i_radius,
    input  logic [15:0]        i_yaw_angle,
    output logic               o_empty,
    input  logic               i_pop,
    output logic               o_hit,
    output logic [15:0]        o_hit_id,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_z,
    output logic [1:0]         o_move_kind,
    output logic               o_last
);
    logic           w_req_valid, w_req_ready;
    ccoq_pkg::t_req w_req;
    ccoq_pkg::t_res w_res;

    ccoq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_req_type  (i_req_type),
        .i_slot      (i_slot),
        .i_entity_id (i_entity_id),
        .i_flags     (i_flags),
        .i_coord_a_x (i_coord_a_x),
        .i_coord_a_z (i_coord_a_z),
        .i_coord_b_x (i_coord_b_x),
        .i_coord_b_z (i_coord_b_z),
        .i_scale_x   (i_scale_x),
        .i_scale_z   (i_scale_z),
        .i_radius    (i_radius),
        .i_yaw_angle (i_yaw_angle),
        .o_full      (o_full),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_ready (w_req_ready)
    );

    ccoq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_ready (w_req_ready),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_res       (w_res)
    );

    assign o_hit       = w_res.hit;
    assign o_hit_id    = w_res.hit_id;
    assign o_out_x     = w_res.out_x;
    assign o_out_z     = w_res.out_z;
    assign o_move_kind = w_res.move_kind;
    assign o_last      = w_res.last;

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_valid && w_req_ready) |=> !w_req_ready)
        else $error("back end took a request while busy");

    a_list_nonfinal_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_last) |-> o_hit)
        else $error("non-final result without an id");

    a_slide_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_move_kind != ccoq_pkg::MK_FULL)) |-> (o_hit && o_last))
        else $error("slide result without blocked full move");
`endif
endmodule
